>>> hdl/feedback_delay_line_assert.svh
// Assertion macros for the feedback delay line checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef FEEDBACK_DELAY_LINE_ASSERT_SVH
`define FEEDBACK_DELAY_LINE_ASSERT_SVH

// same-cycle implication
`define FDL_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FDL_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/fdl_pkg.sv
// Shared types, constants and arithmetic helpers for the feedback delay line.
// No dependencies; imported by every module of the block.
`default_nettype none

package fdl_pkg;

	localparam int SW      = 16;
	localparam int DEPTH   = 262144;
	localparam int AW      = $clog2(DEPTH);
	localparam int FRAC_W  = 16;
	localparam int DFRAC_W = 24;
	localparam int GW      = AW + DFRAC_W;
	localparam int POS_W   = AW + FRAC_W;
	localparam int DT_W    = 18;
	localparam int Q16_W   = 17;
	localparam int GLIDE_W = 18;
	localparam int ACC_W   = SW + 20;
	localparam int CFG_W   = 18;
	localparam int CFG_IDX_W = 2;

	localparam logic [Q16_W-1:0]   UNITY   = Q16_W'(65536);
	localparam logic [GLIDE_W-1:0] GLIDE   = GLIDE_W'(214748);
	localparam logic [AW-1:0]      MAX_IDX = AW'(DEPTH - 1);
	localparam logic [ACC_W-1:0]   HALF_LSB = ACC_W'(32768);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DELAY_TARGET = 2'd0,
		CFG_FEEDBACK     = 2'd1,
		CFG_WET_MIX      = 2'd2,
		CFG_INPUT_GAIN   = 2'd3
	} fdl_cfg_idx_t;

	typedef struct packed {
		logic capture;
		logic fetch;
		logic write;
		logic interp;
		logic wet;
		logic mix;
		logic load_out;
	} fdl_cmd_t;

	// round a Q16 product sum to nearest (ties up) and saturate to SW bits
	function automatic logic signed [SW-1:0] round_sat(input logic signed [ACC_W-1:0] v);
		localparam logic signed [ACC_W-17:0] Q_MAX = (ACC_W-16)'((64'd1 << (SW-1)) - 64'd1);
		localparam logic signed [ACC_W-17:0] Q_MIN = -Q_MAX - (ACC_W-16)'(1);
		logic [ACC_W-1:0]          r;
		logic signed [ACC_W-17:0]  q;
		logic signed [SW-1:0]      res;
		r = v + HALF_LSB;
		q = $signed(r[ACC_W-1:16]);
		if (q > Q_MAX) begin
			res = Q_MAX[SW-1:0];
		end else if (q < Q_MIN) begin
			res = Q_MIN[SW-1:0];
		end else begin
			res = q[SW-1:0];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

>>> hdl/fdl_ctrl.sv
// Sequencer for the feedback delay line: walks one sample through the datapath.
// Depends on fdl_pkg for the command struct.
`default_nettype none

module fdl_ctrl
	import fdl_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	output fdl_cmd_t      cmd
);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_FETCH  = 7'b0000010,
		ST_WRITE  = 7'b0000100,
		ST_INTERP = 7'b0001000,
		ST_WET    = 7'b0010000,
		ST_MIX    = 7'b0100000,
		ST_DONE   = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.capture  = (state_q == ST_IDLE) && in_valid;
		cmd.fetch    = (state_q == ST_FETCH);
		cmd.write    = (state_q == ST_WRITE);
		cmd.interp   = (state_q == ST_INTERP);
		cmd.wet      = (state_q == ST_WET);
		cmd.mix      = (state_q == ST_MIX);
		cmd.load_out = (state_q == ST_DONE) && slot_free;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_FETCH;
			ST_FETCH:  state_d = ST_WRITE;
			ST_WRITE:  state_d = ST_INTERP;
			ST_INTERP: state_d = ST_WET;
			ST_WET:    state_d = ST_MIX;
			ST_MIX:    state_d = ST_DONE;
			ST_DONE:   if (slot_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/fdl_datapath.sv
// Datapath of the feedback delay line: settings, sample buffer, glide, mix.
// Depends on fdl_pkg; driven by fdl_ctrl commands.
`default_nettype none

module fdl_datapath
	import fdl_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_W-1:0]       cfg_data,
	input  wire logic signed [SW-1:0]   sample_in,
	input  wire fdl_cmd_t               cmd,
	output logic signed [SW-1:0]        sample_out
);

	localparam int LO_W  = GW / 2;
	localparam int HI_W  = GW - LO_W;
	localparam int TW    = GW + GLIDE_W + 1;
	localparam int EXT_W = DT_W + AW;

	// settings
	logic [DT_W-1:0]  dt_q;
	logic [Q16_W-1:0] fb_q, mix_q, gain_q;

	// running state
	logic [AW-1:0]    wi_q;
	logic             wrapped_q;
	logic [POS_W-1:0] read_pos_q;
	logic [GW-1:0]    smooth_q;

	// per-sample working registers
	logic signed [SW-1:0]    x_q;
	logic [AW-1:0]           ri_q, rn_q;
	logic [FRAC_W-1:0]       frac_q;
	logic [GW-1:0]           gap_q;
	logic                    dir_q;
	logic [SW-1:0]           rdata_q;
	logic                    rvalid_q;
	logic signed [SW-1:0]    a_old_q, b_old_q, wword_q, wet_q, out_q;
	logic                    hit_a_q, hit_b_q;
	logic signed [ACC_W-1:0] p_in_s1, p_fb_s1, p_dry_s1, pa_s2, pb_s2, p_wet_s3;
	logic [LO_W+GLIDE_W-1:0] gl_lo_s1;
	logic [HI_W+GLIDE_W-1:0] gl_hi_s1;
	logic [TW-33:0]          step_q;

	logic [SW-1:0] buf_q [DEPTH];

	logic [AW-1:0]           ri, raddr, tgt_c;
	logic [GW-1:0]           tq;
	logic                    dir;
	logic [Q16_W-1:0]        fb_c, mix_c;
	logic signed [SW-1:0]    a_old, b_old, wword, a_sel, b_sel;
	logic [TW-1:0]           gl_total;
	logic [ACC_W-1:0]        wet_full;
	logic [GW-1:0]           pos_full;

	assign ri    = read_pos_q[POS_W-1:FRAC_W];
	assign raddr = cmd.fetch ? rn_q : ri;
	assign tgt_c = (EXT_W'(dt_q) > EXT_W'(MAX_IDX)) ? MAX_IDX : dt_q;
	assign tq    = {tgt_c, DFRAC_W'(0)};
	assign dir   = (tq >= smooth_q);
	assign fb_c  = (fb_q > UNITY) ? UNITY : fb_q;
	assign mix_c = (mix_q > UNITY) ? UNITY : mix_q;

	assign a_old = rvalid_q ? $signed(rdata_q) : '0;
	assign b_old = rvalid_q ? $signed(rdata_q) : '0;
	assign wword = round_sat(p_in_s1 + p_fb_s1);
	assign a_sel = hit_a_q ? wword_q : a_old_q;
	assign b_sel = hit_b_q ? wword_q : b_old_q;

	assign gl_total = TW'({gl_hi_s1, LO_W'(0)}) + TW'(gl_lo_s1) + (TW'(1) << 31);
	assign wet_full = pa_s2 + pb_s2 + HALF_LSB;
	assign pos_full = {wi_q, DFRAC_W'(0)} - smooth_q;

	assign sample_out = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q       <= '0;
			fb_q       <= '0;
			mix_q      <= '0;
			gain_q     <= UNITY;
			wi_q       <= '0;
			wrapped_q  <= 1'b0;
			read_pos_q <= '0;
			smooth_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (fdl_cfg_idx_t'(cfg_index))
					CFG_DELAY_TARGET: dt_q   <= cfg_data[DT_W-1:0];
					CFG_FEEDBACK:     fb_q   <= cfg_data[Q16_W-1:0];
					CFG_WET_MIX:      mix_q  <= cfg_data[Q16_W-1:0];
					CFG_INPUT_GAIN:   gain_q <= cfg_data[Q16_W-1:0];
					default: ;
				endcase
			end
			if (cmd.write) begin
				wi_q <= wi_q + AW'(1);
				if (wi_q == MAX_IDX) begin
					wrapped_q <= 1'b1;
				end
			end
			if (cmd.interp) begin
				smooth_q <= dir_q ? smooth_q + GW'(step_q) : smooth_q - GW'(step_q);
			end
			if (cmd.wet) begin
				read_pos_q <= pos_full[GW-1:DFRAC_W-FRAC_W];
			end
		end
	end

	// sample buffer: entries at or past the write index read as zero until the first wrap
	always_ff @(posedge clk) begin
		if (cmd.write) begin
			buf_q[wi_q] <= wword;
		end
		rdata_q  <= buf_q[raddr];
		rvalid_q <= wrapped_q || (raddr < wi_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			x_q    <= sample_in;
			ri_q   <= ri;
			rn_q   <= ri + AW'(1);
			frac_q <= read_pos_q[FRAC_W-1:0];
			dir_q  <= dir;
			gap_q  <= dir ? tq - smooth_q : smooth_q - tq;
		end
		if (cmd.fetch) begin
			a_old_q  <= a_old;
			p_in_s1  <= ACC_W'($signed({1'b0, gain_q}) * x_q);
			p_fb_s1  <= ACC_W'($signed({1'b0, fb_c}) * a_old);
			p_dry_s1 <= ACC_W'($signed({1'b0, UNITY - mix_c}) * x_q);
			gl_lo_s1 <= gap_q[LO_W-1:0] * GLIDE;
			gl_hi_s1 <= gap_q[GW-1:LO_W] * GLIDE;
		end
		if (cmd.write) begin
			b_old_q <= b_old;
			wword_q <= wword;
			hit_a_q <= (ri_q == wi_q);
			hit_b_q <= (rn_q == wi_q);
			step_q  <= gl_total[TW-1:32];
		end
		if (cmd.interp) begin
			pa_s2 <= ACC_W'($signed({1'b0, UNITY - Q16_W'(frac_q)}) * a_sel);
			pb_s2 <= ACC_W'($signed({2'b00, frac_q}) * b_sel);
		end
		if (cmd.wet) begin
			wet_q <= $signed(wet_full[SW+15:16]);
		end
		if (cmd.mix) begin
			p_wet_s3 <= ACC_W'($signed({1'b0, mix_c}) * wet_q);
		end
		if (cmd.load_out) begin
			out_q <= round_sat(p_dry_s1 + p_wet_s3);
		end
	end

endmodule

`default_nettype wire

>>> hdl/feedback_delay_line.sv
// The sequencer steps an accepted sample through two buffer reads, one buffer write
// and the multiply stages in the fetch, write, interp, wet and mix states, then loads
// the output register in done once it is free; a new sample is taken only in idle.
// Reset: settings (gain to unity), write index, read position and glide reset; entries
// not yet written since reset read as zero by write-index fill tracking, no clear pass.
// Top level of the feedback delay line; depends on fdl_pkg, fdl_ctrl, fdl_datapath.
`default_nettype none

module feedback_delay_line
	import fdl_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_W-1:0]       cfg_data,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic signed [SW-1:0]   sample_in,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic signed [SW-1:0]        sample_out
);

	fdl_cmd_t cmd;

	fdl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	fdl_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sample_in  (sample_in),
		.cmd        (cmd),
		.sample_out (sample_out)
	);

endmodule

`default_nettype wire

>>> hdl/fdl_checker.sv
// Port-level checker for the feedback delay line, bound to the top level.
// Depends on fdl_pkg and the macros in feedback_delay_line_assert.svh.
`default_nettype none
`include "feedback_delay_line_assert.svh"

module fdl_checker
	import fdl_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic                 in_ready,
	input  wire logic                 out_valid,
	input  wire logic                 out_ready,
	input  wire logic signed [SW-1:0] sample_out
);

	logic [1:0] pend_q;
	logic       in_beat, out_beat;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(in_beat) - 2'(out_beat);
		end
	end

	`FDL_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(sample_out), "output beat changed while stalled")
	`FDL_ASSERT_NOW(a_no_spurious, clk, arst_n, out_valid, pend_q != 2'd0, "result offered with no sample outstanding")
	`FDL_ASSERT_NOW(a_bounded, clk, arst_n, 1'b1, pend_q != 2'd3, "more than two samples outstanding")
	`FDL_ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_beat, !in_ready, "input taken again while a sample is in work")

endmodule

bind feedback_delay_line fdl_checker u_fdl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.sample_out (sample_out)
);

`default_nettype wire
